// ===== sv/grm_pkg.sv =====
// grm_pkg: shared constants, types and helper functions of the grid ray marcher
// no dependencies; used by grm_front, grm_queue, grm_back, grid_ray_march and tb_top by scoped names
`default_nettype none

package grm_pkg;

   localparam int MAP_COLS  = 64;
   localparam int MAP_ROWS  = 32;
   localparam int MAP_CELLS = MAP_COLS * MAP_ROWS;
   localparam int MAX_DIST  = 4096;
   localparam int STEP_DIST = 16;
   localparam int STEP_SHIFT = 4;
   localparam int FRAC_W    = 8;

   localparam int COL_W   = 6;
   localparam int ROW_W   = 5;
   localparam int TILE_W  = 4;
   localparam int ORGX_W  = 14;
   localparam int ORGY_W  = 13;
   localparam int ANGLE_W = 5;
   localparam int ANGLES  = 32;
   localparam int DIST_W  = 13;
   localparam int CELL_W  = 8;
   localparam int POS_W   = CELL_W + FRAC_W;
   localparam int TRIG_W  = 10;
   localparam int STEP_W  = 6;
   localparam int ADDR_W  = $clog2(MAP_CELLS);

   localparam int STEPS_PER_RAY = MAX_DIST / STEP_DIST - 1;
   localparam int STEPCNT_W     = $clog2(MAX_DIST / STEP_DIST);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_CAST  = 1'b1;

   localparam logic signed [TRIG_W-1:0] COS_TAB [ANGLES] = '{
      10'sd256, 10'sd251, 10'sd237, 10'sd213, 10'sd181, 10'sd142, 10'sd98, 10'sd50,
      10'sd0, -10'sd50, -10'sd98, -10'sd142, -10'sd181, -10'sd213, -10'sd237, -10'sd251,
      -10'sd256, -10'sd251, -10'sd237, -10'sd213, -10'sd181, -10'sd142, -10'sd98, -10'sd50,
      10'sd0, 10'sd50, 10'sd98, 10'sd142, 10'sd181, 10'sd213, 10'sd237, 10'sd251
   };

   typedef struct packed {
      logic                     is_cast;
      logic                     wr_ok;
      logic [ADDR_W-1:0]        wr_addr;
      logic [TILE_W-1:0]        tile;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [STEP_W-1:0] dx;
      logic signed [STEP_W-1:0] dy;
      logic signed [CELL_W-1:0] org_cx;
      logic signed [CELL_W-1:0] org_cy;
   } grm_item_type;

   typedef struct packed {
      logic                     hit;
      logic [DIST_W-1:0]        distance;
      logic signed [CELL_W-1:0] hit_col;
      logic signed [CELL_W-1:0] hit_row;
      logic [COL_W-1:0]         prev_col;
      logic [ROW_W-1:0]         prev_row;
      logic [TILE_W-1:0]        hit_tile;
      logic                     vertical_side;
      logic                     outside_map;
   } grm_result_type;

   // floor of the table entry divided by the step scale
   function automatic logic signed [STEP_W-1:0] step_of(input logic [ANGLE_W-1:0] a);
      logic signed [TRIG_W-1:0] c;
      c = COS_TAB[a];
      return STEP_W'(c >>> STEP_SHIFT);
   endfunction

   function automatic logic in_map(input logic signed [CELL_W-1:0] cx,
                                   input logic signed [CELL_W-1:0] cy);
      return !cx[CELL_W-1] && !cy[CELL_W-1] &&
             (int'(cx) < MAP_COLS) && (int'(cy) < MAP_ROWS);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] row);
      return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAP_COLS) + ADDR_W'(col));
   endfunction

endpackage

`default_nettype wire

// ===== sv/grm_ram.sv =====
// grm_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module grm_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/grm_front.sv =====
// grm_front: classifies an incoming item and precomputes its march setup
// depends on grm_pkg
`default_nettype none

module grm_front (
   input  wire logic                        req_type,
   input  wire logic [grm_pkg::COL_W-1:0]   req_cell_x,
   input  wire logic [grm_pkg::ROW_W-1:0]   req_cell_y,
   input  wire logic [grm_pkg::TILE_W-1:0]  req_cell_tile,
   input  wire logic [grm_pkg::ORGX_W-1:0]  req_origin_x,
   input  wire logic [grm_pkg::ORGY_W-1:0]  req_origin_y,
   input  wire logic [grm_pkg::ANGLE_W-1:0] req_angle,
   output grm_pkg::grm_item_type            item
);

   logic [grm_pkg::ANGLE_W-1:0] angle_y;

   // sine is the cosine a quarter turn back
   assign angle_y = req_angle + grm_pkg::ANGLE_W'(3 * grm_pkg::ANGLES / 4);

   always_comb begin
      item.is_cast = (req_type == grm_pkg::REQ_CAST);
      item.wr_ok   = (int'(req_cell_x) < grm_pkg::MAP_COLS) &&
                     (int'(req_cell_y) < grm_pkg::MAP_ROWS);
      item.wr_addr = grm_pkg::cell_addr(req_cell_x, req_cell_y);
      item.tile    = req_cell_tile;
      item.pos_x   = {{(grm_pkg::POS_W - grm_pkg::ORGX_W){1'b0}}, req_origin_x};
      item.pos_y   = {{(grm_pkg::POS_W - grm_pkg::ORGY_W){1'b0}}, req_origin_y};
      item.dx      = grm_pkg::step_of(req_angle);
      item.dy      = grm_pkg::step_of(angle_y);
      item.org_cx  = item.pos_x[grm_pkg::POS_W-1:grm_pkg::FRAC_W];
      item.org_cy  = item.pos_y[grm_pkg::POS_W-1:grm_pkg::FRAC_W];
   end

endmodule

`default_nettype wire

// ===== sv/grm_queue.sv =====
// grm_queue: short register queue of classified items between front and back
// depends on grm_pkg
`default_nettype none

module grm_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  grm_pkg::grm_item_type      push_item,
   input  wire logic                  pop,
   output logic                       full,
   output logic                       empty,
   output grm_pkg::grm_item_type      head
);

   grm_pkg::grm_item_type              slot_ff [grm_pkg::QUEUE_DEPTH];
   logic [grm_pkg::QPTR_W-1:0]         wr_ptr_ff;
   logic [grm_pkg::QPTR_W-1:0]         rd_ptr_ff;
   logic [grm_pkg::QCNT_W-1:0]         count_ff;
   logic                               do_push;
   logic                               do_pop;

   assign full    = (count_ff == grm_pkg::QCNT_W'(grm_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/grm_back.sv =====
// grm_back: map store, clearing pass, cell writes and the one step per cycle ray march
// depends on grm_pkg and grm_ram
`default_nettype none

module grm_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_empty,
   input  grm_pkg::grm_item_type      q_head,
   output logic                       pop,
   output logic                       clearing,
   output logic                       rsp_valid,
   output grm_pkg::grm_result_type    rsp
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_MARCH
   } state_type;

   state_type                            state_ff;
   logic [grm_pkg::ADDR_W-1:0]           clr_cnt_ff;
   logic [grm_pkg::STEPCNT_W-1:0]        step_ff;
   logic signed [grm_pkg::POS_W-1:0]     x_ff;
   logic signed [grm_pkg::POS_W-1:0]     y_ff;
   logic signed [grm_pkg::STEP_W-1:0]    dx_ff;
   logic signed [grm_pkg::STEP_W-1:0]    dy_ff;
   logic signed [grm_pkg::CELL_W-1:0]    lcx_ff;
   logic signed [grm_pkg::CELL_W-1:0]    lcy_ff;
   logic signed [grm_pkg::CELL_W-1:0]    org_cx_ff;
   logic signed [grm_pkg::CELL_W-1:0]    org_cy_ff;

   // check stage, one step behind the march stage, lines up with the ram read
   logic                                 chk_valid_ff;
   logic                                 chk_inside_ff;
   logic                                 chk_side_ff;
   logic signed [grm_pkg::CELL_W-1:0]    chk_cx_ff;
   logic signed [grm_pkg::CELL_W-1:0]    chk_cy_ff;
   logic signed [grm_pkg::CELL_W-1:0]    chk_pcx_ff;
   logic signed [grm_pkg::CELL_W-1:0]    chk_pcy_ff;
   logic [grm_pkg::STEPCNT_W-1:0]        chk_step_ff;

   logic                                 rsp_valid_ff;
   grm_pkg::grm_result_type              res_ff;

   logic signed [grm_pkg::POS_W-1:0]     x_nxt;
   logic signed [grm_pkg::POS_W-1:0]     y_nxt;
   logic signed [grm_pkg::CELL_W-1:0]    cx_nxt;
   logic signed [grm_pkg::CELL_W-1:0]    cy_nxt;
   logic                                 changed;
   logic                                 in_bounds;
   logic                                 issue_more;
   logic                                 hit_now;

   logic                                 ram_wr_en;
   logic [grm_pkg::ADDR_W-1:0]           ram_wr_addr;
   logic [grm_pkg::TILE_W-1:0]           ram_wr_data;
   logic [grm_pkg::ADDR_W-1:0]           ram_rd_addr;
   logic [grm_pkg::TILE_W-1:0]           ram_rd_data;

   assign x_nxt = x_ff + {{(grm_pkg::POS_W - grm_pkg::STEP_W){dx_ff[grm_pkg::STEP_W-1]}},
                          dx_ff};
   assign y_nxt = y_ff + {{(grm_pkg::POS_W - grm_pkg::STEP_W){dy_ff[grm_pkg::STEP_W-1]}},
                          dy_ff};
   assign cx_nxt  = x_nxt[grm_pkg::POS_W-1:grm_pkg::FRAC_W];
   assign cy_nxt  = y_nxt[grm_pkg::POS_W-1:grm_pkg::FRAC_W];
   assign changed = (cx_nxt != lcx_ff) || (cy_nxt != lcy_ff);
   assign in_bounds = grm_pkg::in_map(cx_nxt, cy_nxt);
   assign issue_more = (step_ff != grm_pkg::STEPCNT_W'(grm_pkg::STEPS_PER_RAY));
   assign hit_now = chk_valid_ff && (!chk_inside_ff || (ram_rd_data != '0));

   assign pop      = (state_ff == S_IDLE) && !q_empty;
   assign clearing = (state_ff == S_CLEAR);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = clr_cnt_ff;
      ram_wr_data = '0;
      if (state_ff == S_CLEAR) begin
         ram_wr_en = 1'b1;
      end else if (pop && !q_head.is_cast && q_head.wr_ok) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = q_head.wr_addr;
         ram_wr_data = q_head.tile;
      end
   end

   assign ram_rd_addr = grm_pkg::cell_addr(cx_nxt[grm_pkg::COL_W-1:0],
                                           cy_nxt[grm_pkg::ROW_W-1:0]);

   grm_ram #(
      .WIDTH(grm_pkg::TILE_W),
      .DEPTH(grm_pkg::MAP_CELLS)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         chk_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == grm_pkg::ADDR_W'(grm_pkg::MAP_CELLS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (pop && q_head.is_cast) begin
                  x_ff         <= q_head.pos_x;
                  y_ff         <= q_head.pos_y;
                  dx_ff        <= q_head.dx;
                  dy_ff        <= q_head.dy;
                  lcx_ff       <= q_head.org_cx;
                  lcy_ff       <= q_head.org_cy;
                  org_cx_ff    <= q_head.org_cx;
                  org_cy_ff    <= q_head.org_cy;
                  step_ff      <= '0;
                  chk_valid_ff <= 1'b0;
                  state_ff     <= S_MARCH;
               end
            end
            S_MARCH: begin
               if (issue_more) begin
                  step_ff <= step_ff + 1'b1;
                  x_ff    <= x_nxt;
                  y_ff    <= y_nxt;
                  if (changed) begin
                     lcx_ff <= cx_nxt;
                     lcy_ff <= cy_nxt;
                  end
                  chk_valid_ff  <= changed;
                  chk_inside_ff <= in_bounds;
                  chk_side_ff   <= (cx_nxt != lcx_ff);
                  chk_cx_ff     <= cx_nxt;
                  chk_cy_ff     <= cy_nxt;
                  chk_pcx_ff    <= lcx_ff;
                  chk_pcy_ff    <= lcy_ff;
                  chk_step_ff   <= step_ff + 1'b1;
               end else begin
                  chk_valid_ff <= 1'b0;
               end
               // a hit overrides the step issued in the same cycle
               if (hit_now) begin
                  rsp_valid_ff         <= 1'b1;
                  res_ff.hit           <= 1'b1;
                  res_ff.distance      <= grm_pkg::DIST_W'(chk_step_ff) << grm_pkg::STEP_SHIFT;
                  res_ff.hit_col       <= chk_cx_ff;
                  res_ff.hit_row       <= chk_cy_ff;
                  res_ff.prev_col      <= chk_pcx_ff[grm_pkg::COL_W-1:0];
                  res_ff.prev_row      <= chk_pcy_ff[grm_pkg::ROW_W-1:0];
                  res_ff.hit_tile      <= chk_inside_ff ? ram_rd_data : '0;
                  res_ff.vertical_side <= chk_side_ff;
                  res_ff.outside_map   <= !chk_inside_ff;
                  state_ff             <= S_IDLE;
               end else if (!issue_more) begin
                  rsp_valid_ff         <= 1'b1;
                  res_ff.hit           <= 1'b0;
                  res_ff.distance      <= grm_pkg::DIST_W'(grm_pkg::MAX_DIST);
                  res_ff.hit_col       <= '1;
                  res_ff.hit_row       <= '1;
                  res_ff.prev_col      <= org_cx_ff[grm_pkg::COL_W-1:0];
                  res_ff.prev_row      <= org_cy_ff[grm_pkg::ROW_W-1:0];
                  res_ff.hit_tile      <= '0;
                  res_ff.vertical_side <= 1'b0;
                  res_ff.outside_map   <= 1'b0;
                  state_ff             <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = res_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   a_from_march: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == S_MARCH)
      else $error("result produced outside of a march");

   a_miss_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !res_ff.hit |->
         res_ff.distance == grm_pkg::DIST_W'(grm_pkg::MAX_DIST) &&
         res_ff.hit_col == '1 && res_ff.hit_tile == '0)
      else $error("miss result carries hit fields");

   a_outside_tile: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.outside_map |-> res_ff.hit && res_ff.hit_tile == '0)
      else $error("outside hit reports a tile");

   a_no_pop_clearing: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !pop && !rsp_valid_ff)
      else $error("queue served during clearing pass");

endmodule

`default_nettype wire

// ===== sv/grid_ray_march.sv =====
// grid_ray_march: fixed-step ray marcher over a 64x32 map of 4-bit tiles, built from
// grm_front, grm_queue and grm_back; a cell write is stored when grm_back pops it from the queue.
// a cast returns its result once the march reaches a hit or runs out of steps;
// the back end takes a write every cycle while idle, but takes no new item while a cast marches.
// reset starts a clearing pass over all 2048 map cells, one map cell per cycle, with busy high.
// results appear as a one-cycle strobe; the receiver cannot stall.
`default_nettype none

module grid_ray_march (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_type,
   input  wire logic [grm_pkg::COL_W-1:0]    req_cell_x,
   input  wire logic [grm_pkg::ROW_W-1:0]    req_cell_y,
   input  wire logic [grm_pkg::TILE_W-1:0]   req_cell_tile,
   input  wire logic [grm_pkg::ORGX_W-1:0]   req_origin_x,
   input  wire logic [grm_pkg::ORGY_W-1:0]   req_origin_y,
   input  wire logic [grm_pkg::ANGLE_W-1:0]  req_angle,
   output logic                              rsp_valid,
   output logic                              rsp_hit,
   output logic [grm_pkg::DIST_W-1:0]        rsp_distance,
   output logic signed [grm_pkg::CELL_W-1:0] rsp_hit_col,
   output logic signed [grm_pkg::CELL_W-1:0] rsp_hit_row,
   output logic [grm_pkg::COL_W-1:0]         rsp_prev_col,
   output logic [grm_pkg::ROW_W-1:0]         rsp_prev_row,
   output logic [grm_pkg::TILE_W-1:0]        rsp_hit_tile,
   output logic                              rsp_vertical_side,
   output logic                              rsp_outside_map
);

   grm_pkg::grm_item_type    front_item;
   grm_pkg::grm_item_type    q_head;
   grm_pkg::grm_result_type  rsp;
   logic                     q_full;
   logic                     q_empty;
   logic                     q_pop;
   logic                     clearing;
   logic                     accept;

   assign busy   = clearing || q_full;
   assign accept = start && !busy;

   grm_front u_front (
      .req_type     (req_type),
      .req_cell_x   (req_cell_x),
      .req_cell_y   (req_cell_y),
      .req_cell_tile(req_cell_tile),
      .req_origin_x (req_origin_x),
      .req_origin_y (req_origin_y),
      .req_angle    (req_angle),
      .item         (front_item)
   );

   grm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_item(front_item),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   grm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .pop      (q_pop),
      .clearing (clearing),
      .rsp_valid(rsp_valid),
      .rsp      (rsp)
   );

   assign rsp_hit           = rsp.hit;
   assign rsp_distance      = rsp.distance;
   assign rsp_hit_col       = rsp.hit_col;
   assign rsp_hit_row       = rsp.hit_row;
   assign rsp_prev_col      = rsp.prev_col;
   assign rsp_prev_row      = rsp.prev_row;
   assign rsp_hit_tile      = rsp.hit_tile;
   assign rsp_vertical_side = rsp.vertical_side;
   assign rsp_outside_map   = rsp.outside_map;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for grid_ray_march, with its own tile map copy and ray predictor
// depends on grm_pkg (port widths, request codes) and the grid_ray_march rtl
`timescale 1ns / 1ps

module tb_top;

   localparam int GRID_COLS = 64;
   localparam int GRID_ROWS = 32;
   localparam int RAY_REACH = 4096;
   localparam int STRIDE    = 16;
   localparam int STEP_SHR  = 4;
   localparam int FRAC      = 8;
   localparam int ORG_X_MAX = 16383;
   localparam int ORG_Y_MAX = 8191;

   typedef struct packed {
      logic                           kind;
      logic [grm_pkg::COL_W-1:0]      cell_x;
      logic [grm_pkg::ROW_W-1:0]      cell_y;
      logic [grm_pkg::TILE_W-1:0]     cell_tile;
      logic [grm_pkg::ORGX_W-1:0]     origin_x;
      logic [grm_pkg::ORGY_W-1:0]     origin_y;
      logic [grm_pkg::ANGLE_W-1:0]    angle;
   } march_req_type;

   typedef struct packed {
      logic                              hit;
      logic [grm_pkg::DIST_W-1:0]        distance;
      logic signed [grm_pkg::CELL_W-1:0] hit_col;
      logic signed [grm_pkg::CELL_W-1:0] hit_row;
      logic [grm_pkg::COL_W-1:0]         prev_col;
      logic [grm_pkg::ROW_W-1:0]         prev_row;
      logic [grm_pkg::TILE_W-1:0]        hit_tile;
      logic                              vertical_side;
      logic                              outside_map;
   } march_res_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic                              req_type;
   logic [grm_pkg::COL_W-1:0]         req_cell_x;
   logic [grm_pkg::ROW_W-1:0]         req_cell_y;
   logic [grm_pkg::TILE_W-1:0]        req_cell_tile;
   logic [grm_pkg::ORGX_W-1:0]        req_origin_x;
   logic [grm_pkg::ORGY_W-1:0]        req_origin_y;
   logic [grm_pkg::ANGLE_W-1:0]       req_angle;
   logic                              rsp_valid;
   logic                              rsp_hit;
   logic [grm_pkg::DIST_W-1:0]        rsp_distance;
   logic signed [grm_pkg::CELL_W-1:0] rsp_hit_col;
   logic signed [grm_pkg::CELL_W-1:0] rsp_hit_row;
   logic [grm_pkg::COL_W-1:0]         rsp_prev_col;
   logic [grm_pkg::ROW_W-1:0]         rsp_prev_row;
   logic [grm_pkg::TILE_W-1:0]        rsp_hit_tile;
   logic                              rsp_vertical_side;
   logic                              rsp_outside_map;

   logic [grm_pkg::TILE_W-1:0] tile_shadow [GRID_COLS*GRID_ROWS];
   march_res_type     cast_results_due [$];
   int unsigned       mismatch_count = 0;
   int                burst_left = 0;
   bit                pace_on = 1'b1;

   grid_ray_march dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_cell_x        (req_cell_x),
      .req_cell_y        (req_cell_y),
      .req_cell_tile     (req_cell_tile),
      .req_origin_x      (req_origin_x),
      .req_origin_y      (req_origin_y),
      .req_angle         (req_angle),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_distance      (rsp_distance),
      .rsp_hit_col       (rsp_hit_col),
      .rsp_hit_row       (rsp_hit_row),
      .rsp_prev_col      (rsp_prev_col),
      .rsp_prev_row      (rsp_prev_row),
      .rsp_hit_tile      (rsp_hit_tile),
      .rsp_vertical_side (rsp_vertical_side),
      .rsp_outside_map   (rsp_outside_map)
   );

   always #4 clock = ~clock;

   // first quadrant of the direction table, scale 256
   function automatic int quarter_cos(input int k);
      case (k)
         0: return 256;
         1: return 251;
         2: return 237;
         3: return 213;
         4: return 181;
         5: return 142;
         6: return 98;
         7: return 50;
         default: return 0;
      endcase
   endfunction

   function automatic int dir_cos(input int a);
      if (a <= 8) return quarter_cos(a);
      if (a <= 16) return -quarter_cos(16 - a);
      if (a <= 24) return -quarter_cos(a - 16);
      return quarter_cos(32 - a);
   endfunction

   function automatic march_res_type march_ray(input march_req_type rq);
      int            px, py, sx, sy, ccx, ccy, lcx, lcy, reach;
      logic [3:0]    t;
      logic          in_grid, done;
      march_res_type r;
      // int is signed, so >>> floors like the hardware shift
      sx  = dir_cos(int'(rq.angle)) >>> STEP_SHR;
      sy  = dir_cos((int'(rq.angle) + 24) % 32) >>> STEP_SHR;
      px  = int'(rq.origin_x);
      py  = int'(rq.origin_y);
      lcx = px >>> FRAC;
      lcy = py >>> FRAC;
      r.hit           = 1'b0;
      r.distance      = grm_pkg::DIST_W'(RAY_REACH);
      r.hit_col       = -8'sd1;
      r.hit_row       = -8'sd1;
      r.prev_col      = grm_pkg::COL_W'(lcx);
      r.prev_row      = grm_pkg::ROW_W'(lcy);
      r.hit_tile      = '0;
      r.vertical_side = 1'b0;
      r.outside_map   = 1'b0;
      done = 1'b0;
      for (reach = STRIDE; reach < RAY_REACH && !done; reach += STRIDE) begin
         px += sx;
         py += sy;
         ccx = px >>> FRAC;
         ccy = py >>> FRAC;
         // only a freshly entered cell is tested, never the origin cell
         if (ccx != lcx || ccy != lcy) begin
            in_grid = ccx >= 0 && ccy >= 0 && ccx < GRID_COLS && ccy < GRID_ROWS;
            t = in_grid ? tile_shadow[ccy*GRID_COLS + ccx] : 4'd0;
            if (!in_grid || t != 4'd0) begin
               done            = 1'b1;
               r.hit           = 1'b1;
               r.distance      = grm_pkg::DIST_W'(reach);
               r.hit_col       = grm_pkg::CELL_W'(ccx);
               r.hit_row       = grm_pkg::CELL_W'(ccy);
               r.prev_col      = grm_pkg::COL_W'(lcx);
               r.prev_row      = grm_pkg::ROW_W'(lcy);
               r.hit_tile      = t;
               r.vertical_side = (ccx != lcx);
               r.outside_map   = !in_grid;
            end else begin
               lcx = ccx;
               lcy = ccy;
            end
         end
      end
      return r;
   endfunction

   function automatic march_req_type any_req();
      march_req_type rq;
      rq.kind      = ($urandom_range(0, 1) == 1) ? grm_pkg::REQ_CAST : grm_pkg::REQ_WRITE;
      rq.cell_x    = grm_pkg::COL_W'($urandom);
      rq.cell_y    = grm_pkg::ROW_W'($urandom);
      rq.cell_tile = grm_pkg::TILE_W'($urandom);
      rq.origin_x  = grm_pkg::ORGX_W'($urandom);
      rq.origin_y  = grm_pkg::ORGY_W'($urandom);
      rq.angle     = grm_pkg::ANGLE_W'($urandom);
      return rq;
   endfunction

   function automatic march_req_type cast_req(input int ox, input int oy, input int ang);
      march_req_type rq;
      rq          = any_req();
      rq.kind     = grm_pkg::REQ_CAST;
      rq.origin_x = grm_pkg::ORGX_W'(ox);
      rq.origin_y = grm_pkg::ORGY_W'(oy);
      rq.angle    = grm_pkg::ANGLE_W'(ang);
      return rq;
   endfunction

   function automatic march_req_type write_req(input int cx, input int cy, input int tile);
      march_req_type rq;
      rq           = any_req();
      rq.kind      = grm_pkg::REQ_WRITE;
      rq.cell_x    = grm_pkg::COL_W'(cx);
      rq.cell_y    = grm_pkg::ROW_W'(cy);
      rq.cell_tile = grm_pkg::TILE_W'(tile);
      return rq;
   endfunction

   task automatic drive_req(input march_req_type rq);
      req_type      <= rq.kind;
      req_cell_x    <= rq.cell_x;
      req_cell_y    <= rq.cell_y;
      req_cell_tile <= rq.cell_tile;
      req_origin_x  <= rq.origin_x;
      req_origin_y  <= rq.origin_y;
      req_angle     <= rq.angle;
   endtask

   task automatic issue_req(input march_req_type rq);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = pace_on ? $urandom_range(0, 10) : 0;
         // idle cycles carry junk on the request fields
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
            drive_req(any_req());
         end
      end
      burst_left--;
      @(negedge clock);
      start <= 1'b1;
      drive_req(rq);
      @(posedge clock);
      while (busy) @(posedge clock);
      if (rq.kind == grm_pkg::REQ_WRITE)
         tile_shadow[int'(rq.cell_y)*GRID_COLS + int'(rq.cell_x)] = rq.cell_tile;
      else
         cast_results_due.push_back(march_ray(rq));
   endtask

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      march_res_type want;
      if (!reset && rsp_valid) begin
         if (cast_results_due.size() == 0) begin
            $display("%0t ns: result with no cast outstanding, expected none, actual hit=%0d",
                     $time, rsp_hit);
            mismatch_count++;
         end else begin
            want = cast_results_due.pop_front();
            check_field("hit", want.hit, rsp_hit);
            check_field("distance", want.distance, rsp_distance);
            check_field("hit_col", want.hit_col, rsp_hit_col);
            check_field("hit_row", want.hit_row, rsp_hit_row);
            check_field("prev_col", want.prev_col, rsp_prev_col);
            check_field("prev_row", want.prev_row, rsp_prev_row);
            check_field("hit_tile", want.hit_tile, rsp_hit_tile);
            check_field("vertical_side", want.vertical_side, rsp_vertical_side);
            check_field("outside_map", want.outside_map, rsp_outside_map);
         end
      end
   end

   // rays on a cleared map: edges of the origin range, runs with no hit, corner exits
   task automatic test_empty_map();
      issue_req(cast_req(0, 0, 16));
      issue_req(cast_req(0, 0, 24));
      issue_req(cast_req(ORG_X_MAX, ORG_Y_MAX, 0));
      issue_req(cast_req(ORG_X_MAX, ORG_Y_MAX, 8));
      issue_req(cast_req(32*256, 16*256, 0));
      issue_req(cast_req(32*256, 16*256, 8));
      issue_req(cast_req(32*256 + 128, 16*256 + 128, 20));
      issue_req(cast_req(5*256, 5*256, 16));
      issue_req(cast_req(0, ORG_Y_MAX, 31));
   endtask

   // solid cells, solid origin cell, clearing a cell again, extreme write fields
   task automatic test_wall_cases();
      issue_req(write_req(0, 0, 15));
      issue_req(write_req(63, 31, 1));
      issue_req(write_req(40, 16, 9));
      issue_req(cast_req(32*256 + 128, 16*256 + 128, 0));
      issue_req(write_req(20, 20, 3));
      issue_req(cast_req(20*256 + 128, 14*256 + 128, 8));
      issue_req(cast_req(40*256 + 128, 16*256 + 128, 16));
      issue_req(cast_req(ORG_X_MAX, ORG_Y_MAX, 20));
      issue_req(cast_req(256 + 10, 256 + 10, 20));
      issue_req(write_req(40, 16, 0));
      issue_req(cast_req(32*256 + 128, 16*256 + 128, 0));
      issue_req(cast_req(22*256 + 200, 18*256 + 60, 4));
      issue_req(write_req(0, 0, 0));
      issue_req(write_req(63, 31, 0));
      issue_req(write_req(20, 20, 0));
   endtask

   // mostly casts over a sparse map, long rays and edge exits
   task automatic test_open_field(input int n);
      march_req_type rq;
      for (int i = 0; i < n; i++) begin
         rq = any_req();
         if ($urandom_range(0, 99) < 85) begin
            rq.kind = grm_pkg::REQ_CAST;
         end else begin
            rq.kind = grm_pkg::REQ_WRITE;
            if ($urandom_range(0, 9) < 7) rq.cell_tile = '0;
         end
         if (i % 64 == 0) pace_on = ($urandom_range(0, 3) != 0);
         issue_req(rq);
      end
   endtask

   // build a cluster of walls, then cast from around it
   task automatic test_walled_rooms(input int n);
      int sent, cx0, cy0, walls, casts, ox, oy;
      march_req_type rq;
      sent = 0;
      while (sent < n) begin
         cx0 = $urandom_range(0, GRID_COLS - 1);
         cy0 = $urandom_range(0, GRID_ROWS - 1);
         walls = $urandom_range(2, 10);
         casts = $urandom_range(2, 8);
         pace_on = ($urandom_range(0, 3) != 0);
         for (int w = 0; w < walls; w++) begin
            rq = write_req(cx0 + $urandom_range(0, 12) - 6, cy0 + $urandom_range(0, 12) - 6,
                           $urandom_range(1, 15));
            if ($urandom_range(0, 9) == 0) rq = any_req();
            issue_req(rq);
         end
         for (int c = 0; c < casts; c++) begin
            ox = cx0*256 + int'($urandom_range(0, 12*256)) - 6*256;
            oy = cy0*256 + int'($urandom_range(0, 12*256)) - 6*256;
            ox = (ox < 0) ? 0 : (ox > ORG_X_MAX) ? ORG_X_MAX : ox;
            oy = (oy < 0) ? 0 : (oy > ORG_Y_MAX) ? ORG_Y_MAX : oy;
            issue_req(cast_req(ox, oy, $urandom_range(0, 31)));
         end
         sent += walls + casts;
      end
   endtask

   // knock walls down again while casting through the gaps
   task automatic test_clearing(input int n);
      march_req_type rq;
      pace_on = 1'b1;
      for (int i = 0; i < n; i++) begin
         rq = any_req();
         if (rq.kind == grm_pkg::REQ_WRITE && $urandom_range(0, 3) != 0) rq.cell_tile = '0;
         issue_req(rq);
      end
   endtask

   initial begin
      foreach (tile_shadow[i]) tile_shadow[i] = '0;
      reset = 1'b1;
      start = 1'b0;
      drive_req('0);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_map();
      test_wall_cases();
      test_open_field(350);
      test_walled_rooms(700);
      test_clearing(300);

      @(negedge clock);
      start <= 1'b0;
      wait (cast_results_due.size() == 0);
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && cast_results_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #12ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== grid_ray_march.f =====
sv/grm_pkg.sv
sv/grm_ram.sv
sv/grm_front.sv
sv/grm_queue.sv
sv/grm_back.sv
sv/grid_ray_march.sv
verif/tb_top.sv
